### rtl/assert_macros.svh
// assertion helpers, clocked on clock and quiet while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/lses_pkg.sv
package lses_pkg;

   localparam int CNT_W      = 4;
   localparam int LINES_W    = 32;
   localparam int CFG_W      = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int PLAN_DEPTH = 4;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHECK_LEN,
      CSR_CHECK_STRING,
      CSR_ESCAPE_LEN,
      CSR_ESCAPE_STRING,
      CSR_CRLF_OUT,
      CSR_WIRE_FORMAT,
      CSR_START_AT_LINE
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       flush_now;
   } req_type;

   typedef struct packed {
      logic [7:0]         out_byte;
      logic               last_of_run;
      logic [LINES_W-1:0] lines_so_far;
   } rsp_type;

   // lengths are stored already clamped to the string size
   typedef struct packed {
      logic [CNT_W-1:0] check_len;
      logic [CNT_W-1:0] escape_len;
      logic             crlf_out;
      logic             wire_format;
   } cfg_type;

   typedef enum logic [1:0] {
      MAIN_NONE,
      MAIN_BYTE,
      MAIN_LF,
      MAIN_CRLF
   } main_kind_type;

   // output segments of one item, in emission order
   typedef enum logic [2:0] {
      PH_PRE,
      PH_ESC,
      PH_CR1,
      PH_MCR,
      PH_MAIN,
      PH_CR2,
      PH_POST
   } phase_type;

   localparam int NUM_PHASES = 7;

   typedef struct packed {
      logic [CNT_W-1:0]   pre_cnt;
      logic [CNT_W-1:0]   esc_cnt;
      logic               cr1;
      main_kind_type      main_kind;
      logic [7:0]         data;
      logic               cr2;
      logic [CNT_W-1:0]   post_cnt;
      logic [LINES_W-1:0] lines_pre;
      logic [LINES_W-1:0] lines_post;
   } plan_type;

   // one bit per phase: segment has at least one byte
   function automatic logic [NUM_PHASES-1:0] plan_live(input plan_type p);
      logic [NUM_PHASES-1:0] live;
      live          = '0;
      live[PH_PRE]  = (p.pre_cnt != '0);
      live[PH_ESC]  = (p.esc_cnt != '0);
      live[PH_CR1]  = p.cr1;
      live[PH_MCR]  = (p.main_kind == MAIN_CRLF);
      live[PH_MAIN] = (p.main_kind != MAIN_NONE);
      live[PH_CR2]  = p.cr2;
      live[PH_POST] = (p.post_cnt != '0);
      return live;
   endfunction

endpackage

### rtl/lses_front.sv
`include "assert_macros.svh"

module lses_front #(
   parameter int MAX_STRING_BYTES = 8,
   parameter int LINE_COUNT_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                take,
   input  lses_pkg::req_type                   req,
   input  lses_pkg::cfg_type                   cfg,
   input  logic [MAX_STRING_BYTES-1:0][7:0]    check_str,
   input  logic                                start_we,
   input  logic                                start_val,
   output logic                                plan_push,
   output lses_pkg::plan_type                  plan
);

   localparam int IDX_W = (MAX_STRING_BYTES > 1) ? $clog2(MAX_STRING_BYTES) : 1;
   localparam int EXT_W = (LINE_COUNT_BITS > lses_pkg::LINES_W) ?
                          LINE_COUNT_BITS : lses_pkg::LINES_W;

   logic                             match_ff, match_in;
   logic [lses_pkg::CNT_W-1:0]       pos_ff, pos_in;
   logic                             held_ff, held_in;
   logic                             first_ff, first_in;
   logic [LINE_COUNT_BITS-1:0]       lines_ff, lines_in;
   logic [EXT_W-1:0]                 lines_pre_ext, lines_post_ext;
   logic                             normal;

   assign lines_pre_ext  = EXT_W'(lines_ff);
   assign lines_post_ext = EXT_W'(lines_in);

   always_comb begin
      match_in = match_ff;
      pos_in   = pos_ff;
      held_in  = held_ff;
      lines_in = lines_ff;
      first_in = first_ff;
      normal   = 1'b0;
      plan           = '0;
      plan.main_kind = lses_pkg::MAIN_NONE;
      plan.data      = req.data_byte;
      plan.lines_pre = lines_pre_ext[lses_pkg::LINES_W-1:0];
      if (take) begin
         first_in = 1'b0;
         if (match_ff) begin
            if (cfg.check_len == '0 || pos_ff >= cfg.check_len) begin
               normal = 1'b1;
            end else if (req.data_byte == check_str[pos_ff[IDX_W-1:0]]) begin
               if (pos_ff + lses_pkg::CNT_W'(1) >= cfg.check_len) begin
                  plan.esc_cnt = cfg.escape_len;
                  match_in     = 1'b0;
                  pos_in       = '0;
               end else begin
                  pos_in = pos_ff + lses_pkg::CNT_W'(1);
               end
            end else begin
               normal = 1'b1;
            end
            if (normal) begin
               plan.pre_cnt = pos_ff;
               match_in     = 1'b0;
               pos_in       = '0;
            end
         end else begin
            normal = 1'b1;
         end
         if (normal) begin
            if (held_ff) begin
               held_in  = 1'b0;
               plan.cr1 = (req.data_byte != lses_pkg::CH_LF);
            end
            if (req.data_byte == lses_pkg::CH_CR && cfg.wire_format && !cfg.crlf_out) begin
               held_in = 1'b1;
            end else if (req.data_byte == lses_pkg::CH_LF) begin
               plan.main_kind = (cfg.crlf_out && !cfg.wire_format) ?
                                lses_pkg::MAIN_CRLF : lses_pkg::MAIN_LF;
               lines_in = lines_ff + LINE_COUNT_BITS'(1);
               match_in = 1'b1;
               pos_in   = '0;
            end else begin
               plan.main_kind = lses_pkg::MAIN_BYTE;
            end
         end
         if (req.flush_now) begin
            if (held_in) begin
               held_in  = 1'b0;
               plan.cr2 = 1'b1;
            end
            if (match_in && pos_in != '0) begin
               plan.post_cnt = pos_in;
               match_in      = 1'b0;
               pos_in        = '0;
            end
         end
      end else if (start_we && first_ff) begin
         match_in = start_val;
         pos_in   = '0;
      end
      plan.lines_post = lines_post_ext[lses_pkg::LINES_W-1:0];
   end

   assign plan_push = take && (|lses_pkg::plan_live(plan));

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
         pos_ff   <= '0;
         held_ff  <= 1'b0;
         first_ff <= 1'b1;
         lines_ff <= '0;
      end else begin
         match_ff <= match_in;
         pos_ff   <= pos_in;
         held_ff  <= held_in;
         first_ff <= first_in;
         lines_ff <= lines_in;
      end
   end

   `ASSERT_IMPLIES(a_pos_idle, !match_ff, pos_ff == '0, "match position set outside a match")
   `ASSERT_NEXT(a_first_gone, take, !first_ff, "first-byte flag survived a transaction")

endmodule

### rtl/lses_plan_fifo.sv
`include "assert_macros.svh"

module lses_plan_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lses_pkg::plan_type din,
   output logic               full,
   input  logic               pop,
   output lses_pkg::plan_type dout,
   output logic               empty
);

   localparam int DEPTH = lses_pkg::PLAN_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lses_pkg::plan_type   entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ff, wr_in;
   logic [PTR_W-1:0]     rd_ff, rd_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign dout  = entry_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= din;
      end
   end

   `ASSERT_ALWAYS(a_count_range, count_ff <= CNT_W'(DEPTH), "plan queue count out of range")
   `ASSERT_IMPLIES(a_no_underflow, pop, !empty, "plan taken from an empty queue")

endmodule

### rtl/lses_back.sv
`include "assert_macros.svh"

module lses_back #(
   parameter int MAX_STRING_BYTES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             plan_valid,
   input  lses_pkg::plan_type               plan,
   output logic                             plan_pop,
   input  logic [MAX_STRING_BYTES-1:0][7:0] check_str,
   input  logic [MAX_STRING_BYTES-1:0][7:0] escape_str,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output lses_pkg::rsp_type                rsp_item
);

   localparam int IDX_W = (MAX_STRING_BYTES > 1) ? $clog2(MAX_STRING_BYTES) : 1;

   lses_pkg::plan_type               cur_ff, cur_in;
   logic                             busy_ff, busy_in;
   lses_pkg::phase_type              ph_ff, ph_in;
   logic [lses_pkg::CNT_W-1:0]       idx_ff, idx_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   lses_pkg::rsp_type                rsp_ff;

   logic [lses_pkg::NUM_PHASES-1:0]  live, live_new;
   logic [lses_pkg::CNT_W-1:0]       seg_len;
   logic                             seg_end;
   logic                             nxt_found;
   lses_pkg::phase_type              nxt_ph, first_ph;
   logic                             emit, last, load;
   logic [7:0]                       byte_out;
   logic [lses_pkg::LINES_W-1:0]     lines_out;

   assign live     = lses_pkg::plan_live(cur_ff);
   assign live_new = lses_pkg::plan_live(plan);

   always_comb begin
      nxt_found = 1'b0;
      nxt_ph    = lses_pkg::PH_PRE;
      for (int p = 0; p < lses_pkg::NUM_PHASES; p++) begin
         if (!nxt_found && p > int'(ph_ff) && live[p]) begin
            nxt_found = 1'b1;
            nxt_ph    = lses_pkg::phase_type'(3'(p));
         end
      end
   end

   always_comb begin
      first_ph = lses_pkg::PH_PRE;
      for (int p = lses_pkg::NUM_PHASES - 1; p >= 0; p--) begin
         if (live_new[p]) begin
            first_ph = lses_pkg::phase_type'(3'(p));
         end
      end
   end

   always_comb begin
      unique case (ph_ff)
         lses_pkg::PH_PRE:  seg_len = cur_ff.pre_cnt;
         lses_pkg::PH_ESC:  seg_len = cur_ff.esc_cnt;
         lses_pkg::PH_POST: seg_len = cur_ff.post_cnt;
         default:           seg_len = lses_pkg::CNT_W'(1);
      endcase
   end

   assign seg_end = (idx_ff + lses_pkg::CNT_W'(1)) >= seg_len;

   // outputs of the sequencer
   always_comb begin
      emit     = busy_ff && (!rsp_valid_ff || rsp_pop);
      last     = seg_end && !nxt_found;
      load     = plan_valid && (!busy_ff || (emit && last));
      plan_pop = load;
      unique case (ph_ff)
         lses_pkg::PH_PRE,
         lses_pkg::PH_POST: byte_out = check_str[idx_ff[IDX_W-1:0]];
         lses_pkg::PH_ESC:  byte_out = escape_str[idx_ff[IDX_W-1:0]];
         lses_pkg::PH_MAIN: byte_out = (cur_ff.main_kind == lses_pkg::MAIN_BYTE) ?
                                       cur_ff.data : lses_pkg::CH_LF;
         default:           byte_out = lses_pkg::CH_CR;
      endcase
      // bytes ahead of the line feed still carry the old count
      lines_out = (ph_ff < lses_pkg::PH_MAIN) ? cur_ff.lines_pre : cur_ff.lines_post;
   end

   // next state of the sequencer
   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      ph_in   = ph_ff;
      idx_in  = idx_ff;
      if (emit) begin
         if (!seg_end) begin
            idx_in = idx_ff + lses_pkg::CNT_W'(1);
         end else if (nxt_found) begin
            ph_in  = nxt_ph;
            idx_in = '0;
         end else begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         cur_in  = plan;
         busy_in = 1'b1;
         ph_in   = first_ph;
         idx_in  = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         ph_ff        <= lses_pkg::PH_PRE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         ph_ff        <= ph_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         rsp_ff.out_byte     <= byte_out;
         rsp_ff.last_of_run  <= last;
         rsp_ff.lines_so_far <= lines_out;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `ASSERT_IMPLIES(a_phase_live, busy_ff, live[ph_ff], "sequencer sits in an empty segment")
   `ASSERT_IMPLIES(a_run_open, rsp_valid_ff && !rsp_ff.last_of_run, busy_ff,
                   "run left open with the sequencer idle")

endmodule

### rtl/line_start_escape_stuffer.sv
// path: plan queue, sequencer item register, result register driving the rsp ports
// throughput: one byte per cycle while results are popped; single-byte items stream at one
//   per cycle and the output sequencer sets the rate
// items that produce nothing are consumed at the front and never reach the back end
// reset: synchronous, clears the control registers, the line count, the held CR and the
//   queue pointers; queue entries, the current item and result data keep their contents
module line_start_escape_stuffer #(
   parameter int MAX_STRING_BYTES = 8,
   parameter int LINE_COUNT_BITS  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  lses_pkg::req_type                 req_item,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output lses_pkg::rsp_type                 rsp_item,
   input  logic                              csr_we,
   input  logic [lses_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lses_pkg::CFG_W-1:0]        csr_wdata
);

   lses_pkg::cfg_type                 cfg_ff;
   logic [MAX_STRING_BYTES-1:0][7:0]  check_ff;
   logic [MAX_STRING_BYTES-1:0][7:0]  escape_ff;
   logic [lses_pkg::CNT_W-1:0]        len_clamped;
   logic                              take;
   logic                              start_we;
   logic                              plan_push, plan_pop, plan_empty;
   lses_pkg::plan_type                plan_front, plan_back;

   assign len_clamped = (csr_wdata[lses_pkg::CNT_W-1:0] > lses_pkg::CNT_W'(MAX_STRING_BYTES)) ?
                        lses_pkg::CNT_W'(MAX_STRING_BYTES) : csr_wdata[lses_pkg::CNT_W-1:0];
   assign start_we    = csr_we && (csr_index == lses_pkg::CSR_START_AT_LINE);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= '0;
         check_ff  <= '0;
         escape_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            lses_pkg::CSR_CHECK_LEN:     cfg_ff.check_len   <= len_clamped;
            lses_pkg::CSR_CHECK_STRING:  check_ff  <= csr_wdata[MAX_STRING_BYTES*8-1:0];
            lses_pkg::CSR_ESCAPE_LEN:    cfg_ff.escape_len  <= len_clamped;
            lses_pkg::CSR_ESCAPE_STRING: escape_ff <= csr_wdata[MAX_STRING_BYTES*8-1:0];
            lses_pkg::CSR_CRLF_OUT:      cfg_ff.crlf_out    <= csr_wdata[0];
            lses_pkg::CSR_WIRE_FORMAT:   cfg_ff.wire_format <= csr_wdata[0];
            // start flag only acts on the front's match state
            default: ;
         endcase
      end
   end

   assign take = req_push && !req_full;

   lses_front #(
      .MAX_STRING_BYTES (MAX_STRING_BYTES),
      .LINE_COUNT_BITS  (LINE_COUNT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .req       (req_item),
      .cfg       (cfg_ff),
      .check_str (check_ff),
      .start_we  (start_we),
      .start_val (csr_wdata[0]),
      .plan_push (plan_push),
      .plan      (plan_front)
   );

   lses_plan_fifo u_queue (
      .clock (clock),
      .reset (reset),
      .push  (plan_push),
      .din   (plan_front),
      .full  (req_full),
      .pop   (plan_pop),
      .dout  (plan_back),
      .empty (plan_empty)
   );

   lses_back #(
      .MAX_STRING_BYTES (MAX_STRING_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .plan_valid (!plan_empty),
      .plan       (plan_back),
      .plan_pop   (plan_pop),
      .check_str  (check_ff),
      .escape_str (escape_ff),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_item   (rsp_item)
   );

endmodule

### dv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 3000;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 8;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_push  = 1'b0;
   logic                           req_full;
   lses_pkg::req_type              req_item  = '0;
   logic                           rsp_empty;
   logic                           rsp_pop   = 1'b0;
   lses_pkg::rsp_type              rsp_item;
   logic                           csr_we    = 1'b0;
   logic [lses_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [lses_pkg::CFG_W-1:0]     csr_wdata = '0;

   // shadow copy of the registers and the stuffing state
   logic [3:0]  check_len_q   = '0;
   logic [3:0]  escape_len_q  = '0;
   logic [63:0] check_str_q   = '0;
   logic [63:0] escape_str_q  = '0;
   logic        crlf_q        = 1'b0;
   logic        wire_q        = 1'b0;
   logic        at_line_start = 1'b0;
   int unsigned match_pos     = 0;
   logic        cr_held       = 1'b0;
   logic [31:0] line_count    = '0;
   logic        no_byte_yet   = 1'b1;

   lses_pkg::rsp_type expected_out[$];
   int          errors        = 0;
   int          items_sent    = 0;
   int          burst_left    = 0;
   logic        gaps_on       = 1'b1;
   logic        stalls_on     = 1'b0;
   int          hold_requests = 0;
   int          hold_seen     = 0;
   int          hold_left     = 0;
   logic        pop_state     = 1'b1;
   int          pop_run       = 0;
   int          idle_cycles   = 0;

   line_start_escape_stuffer uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int clamp_len(logic [3:0] v);
      return (v > 4'd8) ? 8 : int'(v);
   endfunction

   function automatic void emit(logic [7:0] b);
      lses_pkg::rsp_type t;
      t.out_byte     = b;
      t.last_of_run  = 1'b0;
      t.lines_so_far = line_count;
      expected_out.push_back(t);
   endfunction

   function automatic void emit_prefix();
      for (int i = 0; i < match_pos; i++) emit(check_str_q[8*i +: 8]);
      at_line_start = 1'b0;
      match_pos     = 0;
   endfunction

   function automatic void normal_byte(logic [7:0] b);
      if (cr_held) begin
         cr_held = 1'b0;
         if (b != lses_pkg::CH_LF) emit(lses_pkg::CH_CR);
      end
      if (b == lses_pkg::CH_CR && wire_q && !crlf_q) begin
         cr_held = 1'b1;
      end else if (b == lses_pkg::CH_LF) begin
         if (crlf_q && !wire_q) emit(lses_pkg::CH_CR);
         line_count = line_count + 1;
         emit(lses_pkg::CH_LF);
         at_line_start = 1'b1;
         match_pos     = 0;
      end else begin
         emit(b);
      end
   endfunction

   function automatic void stuff_byte(lses_pkg::req_type r);
      int                clen;
      int                first;
      lses_pkg::rsp_type t;
      clen        = clamp_len(check_len_q);
      first       = expected_out.size();
      no_byte_yet = 1'b0;
      if (at_line_start && clen != 0 && match_pos < clen &&
          r.data_byte == check_str_q[8*match_pos +: 8]) begin
         match_pos++;
         if (match_pos >= clen) begin
            for (int i = 0; i < clamp_len(escape_len_q); i++) emit(escape_str_q[8*i +: 8]);
            at_line_start = 1'b0;
            match_pos     = 0;
         end
      end else begin
         if (at_line_start) emit_prefix();
         normal_byte(r.data_byte);
      end
      if (r.flush_now) begin
         if (cr_held) begin
            cr_held = 1'b0;
            emit(lses_pkg::CH_CR);
         end
         if (at_line_start && match_pos > 0) emit_prefix();
      end
      if (expected_out.size() > first) begin
         t = expected_out.pop_back();
         t.last_of_run = 1'b1;
         expected_out.push_back(t);
      end
   endfunction

   function automatic void check_out_byte(lses_pkg::rsp_type got);
      lses_pkg::rsp_type want;
      if (expected_out.size() == 0) begin
         $error("unexpected output byte %h", got.out_byte);
         errors++;
         return;
      end
      want = expected_out.pop_front();
      if (got.out_byte !== want.out_byte) begin
         $error("out_byte expected %h actual %h", want.out_byte, got.out_byte);
         errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
         $error("last_of_run expected %b actual %b", want.last_of_run, got.last_of_run);
         errors++;
      end
      if (got.lines_so_far !== want.lines_so_far) begin
         $error("lines_so_far expected %0d actual %0d", want.lines_so_far, got.lines_so_far);
         errors++;
      end
   endfunction

   // receiver: checks each transaction, then picks the next pop value
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) check_out_byte(rsp_item);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (!stalls_on) begin
            rsp_pop <= 1'b1;
         end else begin
            if (pop_run == 0) begin
               pop_state = !pop_state;
               pop_run   = $urandom_range(1, pop_state ? 8 : 4);
            end
            pop_run--;
            rsp_pop <= pop_state;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input logic [7:0] b, input logic flush);
      lses_pkg::req_type r;
      int                gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = gaps_on ? $urandom_range(0, 5) : 0;
         if (gap != 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      r.data_byte = b;
      r.flush_now = flush;
      req_item <= r;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      stuff_byte(r);
      items_sent++;
   endtask

   task automatic send_text(input string s, input logic flush_last);
      for (int i = 0; i < s.len(); i++) send_item(s[i], flush_last && i == s.len() - 1);
   endtask

   // let the last results drain and the block settle before touching the registers
   task automatic wait_idle();
      req_push <= 1'b0;
      while (expected_out.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input lses_pkg::csr_index_type idx, input logic [63:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         lses_pkg::CSR_CHECK_LEN:     check_len_q  = val[3:0];
         lses_pkg::CSR_CHECK_STRING:  check_str_q  = val;
         lses_pkg::CSR_ESCAPE_LEN:    escape_len_q = val[3:0];
         lses_pkg::CSR_ESCAPE_STRING: escape_str_q = val;
         lses_pkg::CSR_CRLF_OUT:      crlf_q       = val[0];
         lses_pkg::CSR_WIRE_FORMAT:   wire_q       = val[0];
         lses_pkg::CSR_START_AT_LINE: begin
            if (no_byte_yet) begin
               at_line_start = val[0];
               match_pos     = 0;
            end
         end
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [3:0] clen, input logic [63:0] cstr,
                             input logic [3:0] elen, input logic [63:0] estr,
                             input logic crlf, input logic wire_fmt, input logic line_begin);
      wait_idle();
      write_csr(lses_pkg::CSR_CHECK_LEN, 64'(clen));
      write_csr(lses_pkg::CSR_CHECK_STRING, cstr);
      write_csr(lses_pkg::CSR_ESCAPE_LEN, 64'(elen));
      write_csr(lses_pkg::CSR_ESCAPE_STRING, estr);
      write_csr(lses_pkg::CSR_CRLF_OUT, 64'(crlf));
      write_csr(lses_pkg::CSR_WIRE_FORMAT, 64'(wire_fmt));
      write_csr(lses_pkg::CSR_START_AT_LINE, 64'(line_begin));
      csr_we <= 1'b0;
   endtask

   function automatic logic [63:0] pack_str(input string s);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
      return v;
   endfunction

   function automatic logic pick_flush();
      return $urandom_range(0, 9) == 0;
   endfunction

   function automatic logic [7:0] pick_byte(input logic [63:0] cstr);
      case ($urandom_range(0, 5))
         0:       return lses_pkg::CH_CR;
         1:       return lses_pkg::CH_LF;
         2:       return cstr[8*$urandom_range(0, 7) +: 8];
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // start flag written before the first byte makes that byte a line start
   task automatic test_start_flag();
      set_config(4'd1, pack_str("."), 4'd2, pack_str(".."), 1'b0, 1'b0, 1'b1);
      send_text(".x", 1'b0);
      send_item(lses_pkg::CH_LF, 1'b0);
      send_text("..", 1'b0);
   endtask

   task automatic test_line_ends();
      set_config(4'd0, '0, 4'd0, '0, 1'b1, 1'b0, 1'b0);
      send_text("a", 1'b0);
      send_item(lses_pkg::CH_LF, 1'b0);
      set_config(4'd0, '0, 4'd0, '0, 1'b0, 1'b1, 1'b0);
      send_item(lses_pkg::CH_CR, 1'b0);
      send_item(lses_pkg::CH_LF, 1'b0);
      send_item(lses_pkg::CH_CR, 1'b0);
      send_text("b", 1'b0);
      send_item(lses_pkg::CH_CR, 1'b1);
      set_config(4'd0, '0, 4'd0, '0, 1'b1, 1'b1, 1'b0);
      send_item(lses_pkg::CH_CR, 1'b0);
      send_item(lses_pkg::CH_LF, 1'b0);
   endtask

   task automatic test_escape_match();
      set_config(4'd5, pack_str("From "), 4'd6, pack_str(">From "), 1'b0, 1'b0, 1'b1);
      // flush at a line start with nothing matched
      send_item(lses_pkg::CH_LF, 1'b1);
      send_text("From x", 1'b0);
      send_item(lses_pkg::CH_LF, 1'b0);
      send_text("Frx", 1'b0);
      send_item(lses_pkg::CH_LF, 1'b0);
      send_text("F", 1'b1);
      // check string shrinks below the matched prefix
      send_item(lses_pkg::CH_LF, 1'b0);
      send_text("Fr", 1'b0);
      set_config(4'd1, pack_str("From "), 4'd6, pack_str(">From "), 1'b0, 1'b0, 1'b0);
      send_text("o", 1'b0);
      // escaping switched off mid match
      send_item(lses_pkg::CH_LF, 1'b0);
      send_text("F", 1'b0);
      set_config(4'd0, pack_str("From "), 4'd6, pack_str(">From "), 1'b0, 1'b0, 1'b0);
      send_text("z", 1'b0);
   endtask

   task automatic test_extreme_strings();
      logic [63:0] cstr;
      cstr = 64'hFF06_0504_0302_0100;
      // oversized lengths clamp to eight bytes
      set_config(4'd15, cstr, 4'd15, 64'h8040_2010_0804_0201, 1'b0, 1'b0, 1'b0);
      send_item(lses_pkg::CH_LF, 1'b0);
      for (int i = 0; i < 8; i++) send_item(cstr[8*i +: 8], 1'b0);
      // empty escape string swallows the match
      set_config(4'd1, 64'hFF, 4'd0, '1, 1'b0, 1'b0, 1'b0);
      send_item(lses_pkg::CH_LF, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
   endtask

   task automatic test_hold_off();
      set_config(4'd0, '0, 4'd0, '0, 1'b0, 1'b0, 1'b0);
      gaps_on = 1'b0;
      hold_requests++;
      repeat (20) send_item(8'($urandom_range(0, 255)), pick_flush());
      wait_idle();
      gaps_on = 1'b1;
   endtask

   task automatic test_random(input int phases, input int items_per_phase);
      logic [3:0]  clen;
      logic [63:0] cstr;
      logic [1:0]  mode;
      int          eff;
      int          n;
      int          target;
      for (int p = 0; p < phases; p++) begin
         mode = 2'(p);
         clen = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
         eff  = clamp_len(clen);
         cstr = {$urandom, $urandom};
         set_config(clen, cstr, 4'($urandom_range(0, 15)), {$urandom, $urandom},
                    mode[0], mode[1], 1'($urandom_range(0, 1)));
         stalls_on = ((p % 2) != 0);
         target    = items_sent + items_per_phase;
         while (items_sent < target) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  // line end followed by all or part of the check string
                  if (mode[1] && $urandom_range(0, 1)) send_item(lses_pkg::CH_CR, 1'b0);
                  send_item(lses_pkg::CH_LF, pick_flush());
                  n = $urandom_range(0, 1) ? eff : $urandom_range(0, eff);
                  for (int k = 0; k < n; k++) send_item(cstr[8*k +: 8], pick_flush());
                  repeat ($urandom_range(1, 4)) send_item(pick_byte(cstr), pick_flush());
               end
               6, 7: repeat ($urandom_range(1, 4))
                  send_item(8'($urandom_range(0, 255)), pick_flush());
               default: begin
                  send_item(lses_pkg::CH_CR, pick_flush());
                  send_item(pick_byte(cstr), pick_flush());
               end
            endcase
         end
      end
      stalls_on = 1'b1;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_start_flag();
      test_line_ends();
      test_escape_match();
      test_extreme_strings();
      test_hold_off();
      test_random(4, 8);
      wait_idle();
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_out.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
